>>> rtl/core/bfp_pkg.sv
// Shared types and constants for the grayscale bilateral filter core.
// No dependencies; imported by every module of the core.
package bfp_pkg;

    localparam int IMAGE_SIDE    = 128;
    localparam int COORD_W       = $clog2(IMAGE_SIDE);
    localparam int ADDR_W        = 2 * COORD_W;
    localparam int MAX_DIAMETER  = 7;
    localparam int HALF_MAX      = MAX_DIAMETER / 2;
    localparam int SPATIAL_DEPTH = 2 * HALF_MAX * HALF_MAX + 1;
    localparam int DIST_W        = $clog2(SPATIAL_DEPTH);
    localparam int RANGE_DEPTH   = 256;
    localparam int WEIGHT_BITS   = 16;
    localparam int WT_W          = 2 * WEIGHT_BITS;
    localparam int WSUM_W        = WT_W + 6;
    localparam int ACC_W         = WT_W + 8 + 6;
    localparam int QDEPTH        = 2;

    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_RANGE   = 2'd1;
    localparam logic [1:0] KIND_SPATIAL = 2'd2;
    localparam logic [1:0] KIND_FILTER  = 2'd3;

    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_DIAMETER = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         idx;
        logic [15:0]        val;
    } req_t;

    typedef struct packed {
        logic [7:0] width;
        logic [7:0] height;
        logic [2:0] diameter;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
    } front_stat_t;

    typedef struct packed {
        logic busy;
    } back_stat_t;

endpackage

>>> rtl/core/bfp_front.sv
// Front end: accepts requests and holds them in a short queue for the back end.
// Depends on bfp_pkg.
module bfp_front
    import bfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    input  logic [7:0]         table_index,
    input  logic [15:0]        write_value,
    output logic               head_valid,
    output req_t               head,
    input  logic               pop,
    output front_stat_t        stat
);

    req_t       q_mem [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    req_t       req_in;

    assign in_stall   = (count_reg == 2'(QDEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_mem[rd_ptr_reg];
    assign stat.count = count_reg;

    // Pixel writes keep only the byte; weights keep WEIGHT_BITS bits.
    always_comb
    begin
        req_in.kind = kind;
        req_in.x    = pixel_x;
        req_in.y    = pixel_y;
        req_in.idx  = table_index;
        req_in.val  = (kind == KIND_PIXEL) ? {8'd0, write_value[7:0]} : write_value;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= req_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/bfp_back.sv
// Back end: image and weight stores, window walk, multiply-accumulate,
// restoring divider and output register. Depends on bfp_pkg.
module bfp_back
    import bfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               head_valid,
    input  req_t               head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic [7:0]         filtered_value,
    output logic               weight_sum_zero,
    output back_stat_t         stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CREQ   = 4'd1;
    localparam logic [3:0] S_CWAIT  = 4'd2;
    localparam logic [3:0] S_NREQ   = 4'd3;
    localparam logic [3:0] S_NRANGE = 4'd4;
    localparam logic [3:0] S_NMUL   = 4'd5;
    localparam logic [3:0] S_NACC   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [7:0]             img_mem [IMAGE_SIDE*IMAGE_SIDE];
    logic [WEIGHT_BITS-1:0] rw_mem [RANGE_DEPTH];
    logic [WEIGHT_BITS-1:0] sw_tab [SPATIAL_DEPTH];

    logic [3:0]             state_reg, state_next;
    logic [COORD_W-1:0]     px_reg, py_reg;
    logic [7:0]             w_reg, h_reg;
    logic [2:0]             d_reg;
    logic [1:0]             half_reg;
    logic [2:0]             i_reg, j_reg;
    logic [7:0]             centre_reg, nv_reg;
    logic [WEIGHT_BITS-1:0] sw_reg;
    logic [WT_W-1:0]        wt_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [WSUM_W-1:0]      wsum_reg;
    logic [2:0]             k_reg;
    logic [7:0]             q_reg;
    logic                   ov_reg;
    logic [COORD_W-1:0]     ox_reg, oy_reg;
    logic [7:0]             ofv_reg;
    logic                   oz_reg;

    logic [ADDR_W-1:0]      img_raddr;
    logic [7:0]             img_rdata;
    logic [7:0]             rw_raddr;
    logic [WEIGHT_BITS-1:0] rw_rdata;

    logic [7:0]             w_lim, h_lim;
    logic signed [3:0]      dx, dy;
    logic [2:0]             adx, ady;
    logic [DIST_W-1:0]      sq_dist;
    logic signed [8:0]      nx_raw, ny_raw;
    logic [COORD_W-1:0]     nx, ny, cx, cy;
    logic [7:0]             diff;
    logic [ACC_W-1:0]       cand;
    logic                   last_j, last_i;

    assign w_lim = (cfg.width == 8'd0) ? 8'd1
                 : (cfg.width > 8'(IMAGE_SIDE)) ? 8'(IMAGE_SIDE) : cfg.width;
    assign h_lim = (cfg.height == 8'd0) ? 8'd1
                 : (cfg.height > 8'(IMAGE_SIDE)) ? 8'(IMAGE_SIDE) : cfg.height;

    assign dx  = $signed({1'b0, i_reg}) - $signed({2'b00, half_reg});
    assign dy  = $signed({1'b0, j_reg}) - $signed({2'b00, half_reg});
    assign adx = dx[3] ? 3'(-dx) : dx[2:0];
    assign ady = dy[3] ? 3'(-dy) : dy[2:0];
    assign sq_dist = DIST_W'(adx * adx) + DIST_W'(ady * ady);

    // Clamp neighbour coordinates to the image edge.
    assign nx_raw = $signed({2'b00, px_reg}) + 9'(dx);
    assign ny_raw = $signed({2'b00, py_reg}) + 9'(dy);
    always_comb
    begin
        priority if (nx_raw < 0)
            nx = '0;
        else if (nx_raw >= $signed({1'b0, w_reg}))
            nx = COORD_W'(w_reg - 8'd1);
        else
            nx = nx_raw[COORD_W-1:0];
        priority if (ny_raw < 0)
            ny = '0;
        else if (ny_raw >= $signed({1'b0, h_reg}))
            ny = COORD_W'(h_reg - 8'd1);
        else
            ny = ny_raw[COORD_W-1:0];
    end

    assign cx = ({1'b0, px_reg} >= w_reg) ? COORD_W'(w_reg - 8'd1) : px_reg;
    assign cy = ({1'b0, py_reg} >= h_reg) ? COORD_W'(h_reg - 8'd1) : py_reg;

    assign img_raddr = (state_reg == S_CREQ) ? {cy, cx} : {ny, nx};
    assign diff      = (img_rdata >= centre_reg) ? img_rdata - centre_reg
                                                 : centre_reg - img_rdata;
    assign rw_raddr  = diff;
    assign cand      = ACC_W'(wsum_reg) << k_reg;
    assign last_j    = (j_reg == d_reg - 3'd1);
    assign last_i    = (i_reg == d_reg - 3'd1);

    assign pop = (state_reg == S_IDLE) && head_valid;

    // Stores: one write port each, registered reads.
    always_ff @(posedge clk)
    begin
        if (pop && head.kind == KIND_PIXEL)
        begin
            img_mem[{head.y, head.x}] <= head.val[7:0];
        end
        img_rdata <= img_mem[img_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.kind == KIND_RANGE)
        begin
            rw_mem[head.idx] <= head.val[WEIGHT_BITS-1:0];
        end
        rw_rdata <= rw_mem[rw_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.kind == KIND_SPATIAL && head.idx < 8'(SPATIAL_DEPTH))
        begin
            sw_tab[head.idx[DIST_W-1:0]] <= head.val[WEIGHT_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid && head.kind == KIND_FILTER)
                    state_next = S_CREQ;
            end
            S_CREQ:   state_next = S_CWAIT;
            S_CWAIT:  state_next = (d_reg == 3'd0) ? S_OUT : S_NREQ;
            S_NREQ:   state_next = S_NRANGE;
            S_NRANGE: state_next = S_NMUL;
            S_NMUL:   state_next = S_NACC;
            S_NACC:
            begin
                if (last_j && last_i)
                    state_next = (wsum_reg == '0 && wt_reg == '0) ? S_OUT : S_DIV;
                else
                    state_next = S_NREQ;
            end
            S_DIV:    state_next = (k_reg == 3'd0) ? S_OUT : S_DIV;
            S_OUT:    state_next = (!ov_reg || !out_stall) ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                px_reg   <= head.x;
                py_reg   <= head.y;
                w_reg    <= w_lim;
                h_reg    <= h_lim;
                d_reg    <= cfg.diameter;
                half_reg <= cfg.diameter[2:1];
                i_reg    <= 3'd0;
                j_reg    <= 3'd0;
                acc_reg  <= '0;
                wsum_reg <= '0;
                k_reg    <= 3'd7;
                q_reg    <= 8'd0;
            end
            S_CWAIT:  centre_reg <= img_rdata;
            S_NREQ:   sw_reg <= (sq_dist < DIST_W'(SPATIAL_DEPTH)) ? sw_tab[sq_dist] : '0;
            S_NRANGE: nv_reg <= img_rdata;
            S_NMUL:   wt_reg <= WT_W'(rw_rdata) * WT_W'(sw_reg);
            S_NACC:
            begin
                acc_reg  <= acc_reg + ACC_W'(wt_reg * {{(WT_W-8){1'b0}}, nv_reg});
                wsum_reg <= wsum_reg + WSUM_W'(wt_reg);
                if (last_j)
                begin
                    j_reg <= 3'd0;
                    i_reg <= i_reg + 3'd1;
                end
                else
                begin
                    j_reg <= j_reg + 3'd1;
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle; the mean of bytes fits in 8 bits.
                if (acc_reg >= cand)
                begin
                    acc_reg <= acc_reg - cand;
                    q_reg   <= {q_reg[6:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[6:0], 1'b0};
                end
                k_reg <= k_reg - 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ov_reg || !out_stall))
        begin
            ox_reg  <= px_reg;
            oy_reg  <= py_reg;
            oz_reg  <= (wsum_reg == '0);
            ofv_reg <= (wsum_reg == '0) ? centre_reg : q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid       = ov_reg;
    assign out_x           = ox_reg;
    assign out_y           = oy_reg;
    assign filtered_value  = ofv_reg;
    assign weight_sum_zero = oz_reg;
    assign stat.busy       = (state_reg != S_IDLE);

endmodule

>>> rtl/core/bilateral_filter_pixel_core.sv
// Filter request: for window side d, a walk over the d*d window through one image port, with
// read, lookup, multiply and accumulate steps per neighbour, then 8 divide steps.
// Pixel and table writes are stored by the back end as they leave a 2-entry queue that decouples input.
// Result sits in an output register, so a new request proceeds while it waits.
// Reset (rst_n, async low) clears control and loads width 128, height 128, diameter 5;
// image and weight stores are undefined until written.
module bilateral_filter_pixel_core
    import bfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    input  logic [7:0]         table_index,
    input  logic [15:0]        write_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic [7:0]         filtered_value,
    output logic               weight_sum_zero
);

    cfg_t        cfg_reg, cfg_next;
    logic        head_valid;
    req_t        head;
    logic        pop;
    front_stat_t fstat;
    back_stat_t  bstat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:    cfg_next.width    = cfg_data;
                CFG_HEIGHT:   cfg_next.height   = cfg_data;
                CFG_DIAMETER: cfg_next.diameter = cfg_data[2:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width    <= 8'd128;
            cfg_reg.height   <= 8'd128;
            cfg_reg.diameter <= 3'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .table_index (table_index),
        .write_value (write_value),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .stat        (fstat)
    );

    bfp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_x           (out_x),
        .out_y           (out_y),
        .filtered_value  (filtered_value),
        .weight_sum_zero (weight_sum_zero),
        .stat            (bstat)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.count <= 2'(QDEPTH))
        else $error("request queue overfilled");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(bstat.busy))
        else $error("result appeared without a request in progress");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid && !$past(pop && fstat.count == 2'd1 && !in_valid))
        else $error("pop from empty queue");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench for bilateral_filter_pixel_core.
// Depends on bfp_pkg and the core RTL. It keeps a model of the image and the weight tables,
// predicts every filter result and checks it against the core output.
`timescale 1ns / 100ps

module testbench;
    import bfp_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         value;
        logic               zero;
    } pixel_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         table_index;
    logic [15:0]        write_value;
    logic               out_valid;
    logic               out_stall;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [7:0]         filtered_value;
    logic               weight_sum_zero;

    bilateral_filter_pixel_core dut (.*);

    // mirror of the core state
    logic [7:0]  image_mirror [IMAGE_SIDE*IMAGE_SIDE];
    logic [15:0] range_mirror [RANGE_DEPTH];
    logic [15:0] spatial_mirror [SPATIAL_DEPTH];
    bit          pixel_written [IMAGE_SIDE*IMAGE_SIDE];
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [2:0]  diameter_reg;

    req_t          pending_requests [$];
    pixel_result_t expected_pixels [$];
    req_t          cur_req;
    int            errors;
    int            tx_gap;
    int            rx_gap;
    bit            tx_idle_on;
    bit            rx_idle_on;
    logic          in_taken;
    logic          out_taken;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int limit_side(logic [7:0] v);
        if (v == 0) return 1;
        if (v > IMAGE_SIDE) return IMAGE_SIDE;
        return v;
    endfunction

    function automatic int clamp(int c, int size);
        if (c < 0) return 0;
        if (c >= size) return size - 1;
        return c;
    endfunction

    function automatic int diameter_used();
        return (diameter_reg > MAX_DIAMETER) ? MAX_DIAMETER : diameter_reg;
    endfunction

    // update the mirror with one accepted request, queue its result if any
    function automatic void apply_request(req_t r);
        int w, h, d, half, cx, cy, dx, dy, nx, ny;
        int unsigned centre, nv, diff, sq_dist;
        longint unsigned acc, wsum, wt, sw;
        pixel_result_t res;
        case (r.kind)
            KIND_PIXEL:   image_mirror[{r.y, r.x}] = r.val[7:0];
            KIND_RANGE:   range_mirror[r.idx] = r.val;
            KIND_SPATIAL: if (r.idx < SPATIAL_DEPTH) spatial_mirror[r.idx] = r.val;
            default:
            begin
                w = limit_side(width_reg);
                h = limit_side(height_reg);
                d = diameter_used();
                half = d / 2;
                cx = clamp(r.x, w);
                cy = clamp(r.y, h);
                centre = image_mirror[cy*IMAGE_SIDE + cx];
                acc = 0;
                wsum = 0;
                for (int i = 0; i < d; i++)
                begin
                    for (int j = 0; j < d; j++)
                    begin
                        dx = i - half;
                        dy = j - half;
                        nx = clamp(int'(r.x) + dx, w);
                        ny = clamp(int'(r.y) + dy, h);
                        nv = image_mirror[ny*IMAGE_SIDE + nx];
                        diff = (nv >= centre) ? nv - centre : centre - nv;
                        sq_dist = dx*dx + dy*dy;
                        sw = (sq_dist < SPATIAL_DEPTH) ? spatial_mirror[sq_dist] : 0;
                        wt = range_mirror[diff[7:0]] * sw;
                        acc += wt * nv;
                        wsum += wt;
                    end
                end
                res.x = r.x;
                res.y = r.y;
                res.zero = (wsum == 0);
                res.value = res.zero ? centre[7:0] : 8'(acc / wsum);
                expected_pixels.push_back(res);
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d value=%0d zero=%0b", $time,
                         out_x, out_y, filtered_value, weight_sum_zero);
                errors++;
            end
            else
            begin
                pixel_result_t e;
                e = expected_pixels.pop_front();
                if (e.x !== out_x || e.y !== out_y || e.value !== filtered_value ||
                    e.zero !== weight_sum_zero)
                begin
                    $display("%0t: mismatch expected x=%0d y=%0d value=%0d zero=%0b", $time,
                             e.x, e.y, e.value, e.zero);
                    $display("%0t:          actual   x=%0d y=%0d value=%0d zero=%0b", $time,
                             out_x, out_y, filtered_value, weight_sum_zero);
                    errors++;
                end
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        logic next_valid;
        next_valid = in_valid;
        if (rst_n && in_valid && in_taken)
        begin
            apply_request(cur_req);
            next_valid = 1'b0;
            tx_gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        end
        if (rst_n && !next_valid)
        begin
            if (tx_gap > 0)
                tx_gap--;
            else if (pending_requests.size() > 0)
            begin
                cur_req = pending_requests.pop_front();
                kind <= cur_req.kind;
                pixel_x <= cur_req.x;
                pixel_y <= cur_req.y;
                table_index <= cur_req.idx;
                write_value <= cur_req.val;
                next_valid = 1'b1;
            end
        end
        in_valid <= next_valid;
    end

    // result receiver stall
    always @(negedge clk)
    begin
        if (rst_n && out_taken)
            rx_gap = rx_idle_on ? $urandom_range(0, 14) : 0;
        if (rx_gap > 0)
        begin
            out_stall <= 1'b1;
            rx_gap--;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [15:0] random_weight();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // keep filter centres near the image edges so the windows reuse pixels
    function automatic int pick_coord(int size);
        int lo;
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 3);
        lo = (size > 4) ? size - 4 : 0;
        return $urandom_range(lo, (size + 3 > 127) ? 127 : size + 3);
    endfunction

    task automatic push(logic [1:0] k, int x, int y, int idx, logic [15:0] val);
        req_t r;
        r.kind = k;
        r.x = COORD_W'(x);
        r.y = COORD_W'(y);
        r.idx = 8'(idx);
        r.val = val;
        if (k == KIND_PIXEL) pixel_written[{r.y, r.x}] = 1'b1;
        pending_requests.push_back(r);
    endtask

    // write any pixel of the window that the request would read before it was written
    task automatic push_filter(int x, int y);
        int w, h, d, half, nx, ny;
        w = limit_side(width_reg);
        h = limit_side(height_reg);
        d = diameter_used();
        half = d / 2;
        nx = clamp(x, w);
        ny = clamp(y, h);
        if (!pixel_written[ny*IMAGE_SIDE + nx])
            push(KIND_PIXEL, nx, ny, $urandom_range(0, 255), 16'($urandom));
        for (int i = 0; i < d; i++)
        begin
            for (int j = 0; j < d; j++)
            begin
                nx = clamp(x + i - half, w);
                ny = clamp(y + j - half, h);
                if (!pixel_written[ny*IMAGE_SIDE + nx])
                    push(KIND_PIXEL, nx, ny, $urandom_range(0, 255), 16'($urandom));
            end
        end
        push(KIND_FILTER, x, y, $urandom_range(0, 255), 16'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [7:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_WIDTH:    width_reg = data;
            CFG_HEIGHT:   height_reg = data;
            CFG_DIAMETER: diameter_reg = data[2:0];
            default: ;
        endcase
    endtask

    task automatic random_phase(int count);
        int w, h;
        w = limit_side(width_reg);
        h = limit_side(height_reg);
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                    push(KIND_PIXEL, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 255), 16'($urandom));
                3, 4:
                    push(KIND_RANGE, 0, 0, $urandom_range(0, 255), random_weight());
                5, 6:
                    push(KIND_SPATIAL, $urandom_range(0, 127), $urandom_range(0, 127),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 20),
                         random_weight());
                default:
                    push_filter(pick_coord(w), pick_coord(h));
            endcase
        end
    endtask

    initial
    begin
        logic [7:0] phase_cfg [10][3];
        phase_cfg = '{'{8, 8, 3}, '{1, 1, 1}, '{128, 128, 7}, '{0, 0, 0},
                      '{255, 200, 7}, '{17, 5, 2}, '{128, 1, 6}, '{3, 128, 4},
                      '{40, 33, 7}, '{128, 128, 5}};
        errors = 0;
        tx_gap = 0;
        rx_gap = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        kind = KIND_PIXEL;
        pixel_x = '0;
        pixel_y = '0;
        table_index = '0;
        write_value = '0;
        width_reg = 8'd128;
        height_reg = 8'd128;
        diameter_reg = 3'd5;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < RANGE_DEPTH; i++)
            push(KIND_RANGE, 0, 0, i, random_weight());
        for (int i = 0; i < SPATIAL_DEPTH; i++)
            push(KIND_SPATIAL, 0, 0, i, 16'($urandom_range(1, 16'hFFFF)));

        // directed: field extremes at the reset configuration
        push(KIND_PIXEL, 0, 0, 255, 16'hFF00);
        push(KIND_PIXEL, 127, 127, 0, 16'hFFFF);
        push(KIND_RANGE, 0, 0, 255, 16'hFFFF);
        push(KIND_SPATIAL, 0, 0, 255, 16'hFFFF);
        push(KIND_SPATIAL, 0, 0, SPATIAL_DEPTH, 16'h0000);
        push_filter(0, 0);
        push_filter(127, 127);
        push_filter(0, 127);
        push_filter(64, 64);
        // hold off until every result has arrived
        wait_idle();

        foreach (phase_cfg[p])
        begin
            write_reg(CFG_WIDTH, phase_cfg[p][0]);
            write_reg(CFG_HEIGHT, phase_cfg[p][1]);
            write_reg(CFG_DIAMETER, phase_cfg[p][2]);
            if (p == 3) write_reg(CFG_SPARE, 8'hA5);
            tx_idle_on = (p % 3) != 1;
            rx_idle_on = (p % 4) != 2;
            // zero weight sum: range weight 0 cleared, so the 1x1 window of this phase has no weight
            if (p == 1)
            begin
                push(KIND_RANGE, 0, 0, 0, 16'h0000);
                push_filter(0, 0);
                push_filter(100, 90);
            end
            push_filter(phase_cfg[p][0] > 127 ? 127 : phase_cfg[p][0], 0);
            random_phase(95);
            wait_idle();
        end

        if (errors == 0)
            $display("bilateral_filter_pixel_core test passed");
        else
            $display("bilateral_filter_pixel_core test failed");
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("bilateral_filter_pixel_core test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bfp_pkg.sv
rtl/core/bfp_front.sv
rtl/core/bfp_back.sv
rtl/core/bilateral_filter_pixel_core.sv
verif/testbench.sv
